// File: hdl/assert_macros.svh
// Assertion macros for the temperature sensor supervisor.
// Expects a clock named clk and a synchronous active high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define TSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that holds at every clock edge out of reset.
`define TSS_ALWAYS(lbl, expr, msg) \
  `TSS_ASSERT(lbl, expr, msg)

`endif

// File: hdl/tss_pkg.sv
// Types and constants of the temperature sensor supervisor.
// Used by temp_sensor_supervisor; depends on nothing else.
package tss_pkg;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 32;

  localparam logic [CfgIndexW-1:0] CfgPresentMask = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgHighLimit   = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgMaxJump     = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgStreakLimit = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgCooldownMs  = 3'd4;

  localparam logic [2:0]         ResetPresentMask = 3'd7;
  localparam logic signed [11:0] ResetHighLimit   = 12'sd1360;
  localparam logic [11:0]        ResetMaxJump     = 12'd160;
  localparam logic [7:0]         ResetStreakLimit = 8'd5;
  localparam logic [31:0]        ResetCooldownMs  = 32'd60000;

  localparam logic signed [11:0] DisconnectedRaw = -12'sd2032;
  localparam logic signed [11:0] LowLimitRaw     = -12'sd880;
  localparam logic [31:0]        RequestPeriodMs = 32'd1000;
  localparam logic [31:0]        ConversionMs    = 32'd750;
  localparam logic [31:0]        ReinitWaitMs    = 32'd500;
  localparam logic [7:0]         StreakMax       = 8'd255;

  typedef enum logic [2:0] {
    Q_UNKNOWN,
    Q_OK,
    Q_MISSING,
    Q_IMPLAUSIBLE,
    Q_RECOVERING
  } quality_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_POWER_OFF,
    PH_WAIT_REINIT
  } phase_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               powered;
    logic               cycling;
    logic signed [11:0] raw_return;
    logic signed [11:0] raw_boiler;
    logic signed [11:0] raw_outdoor;
  } tick_word_t;

  typedef struct packed {
    logic               request_conversion;
    logic               reinit_buses;
    logic               start_power_cycle;
    logic               read_done;
    quality_t           quality_return;
    quality_t           quality_boiler;
    quality_t           quality_outdoor;
    logic signed [11:0] temp_return;
    logic signed [11:0] temp_boiler;
    logic signed [11:0] temp_outdoor;
  } res_word_t;

endpackage

// File: hdl/temp_sensor_supervisor.sv
// Temperature sensor supervisor: request pacing, qualification, bus recovery.
// Depends on tss_pkg and assert_macros.svh.
//
// One tick word a cycle is taken; its result word sits in the output register
// in the next cycle, and a new tick is taken in the same cycle as the previous
// result leaves, so the sustained rate is one word per clock while the result
// side does not stall. Latency and rate are set by the single stage of 32-bit
// time subtractions and compares in front of the state and output registers.
// Configuration registers are written at each clock with cfg_write high, out of reset.
`include "assert_macros.svh"

module temp_sensor_supervisor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             tick_valid,
  output logic                             tick_stall,
  input  tss_pkg::tick_word_t              tick_word,
  output logic                             res_valid,
  input  logic                             res_stall,
  output tss_pkg::res_word_t               res_word,
  input  logic                             cfg_write,
  input  logic [tss_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [tss_pkg::CfgDataW-1:0]     cfg_data
);

  logic [2:0]         present_mask;
  logic signed [11:0] high_limit;
  logic [11:0]        max_jump;
  logic [7:0]         streak_limit;
  logic [31:0]        cooldown_ms;

  logic [2:0]          lg_valid, lg_valid_next;
  logic signed [11:0]  lg_value [3];
  logic signed [11:0]  lg_value_next [3];
  tss_pkg::quality_t   held_quality [3];
  tss_pkg::quality_t   held_quality_next [3];
  logic signed [11:0]  held_temp [3];
  logic signed [11:0]  held_temp_next [3];
  tss_pkg::phase_t     phase, phase_next;
  logic                recovering_bus, recovering_bus_next;
  logic [31:0]         wait_until, wait_until_next;
  logic [7:0]          error_streak [2];
  logic [7:0]          error_streak_next [2];
  logic [1:0]          bus_recovering, bus_recovering_next;
  logic [31:0]         last_recovery [2];
  logic [31:0]         last_recovery_next [2];
  logic [31:0]         last_request, last_request_next;
  logic [31:0]         read_time, read_time_next;

  logic                accept;
  logic signed [11:0]  raw [3];
  logic                req, reinit, pcycle, rdone;
  logic [31:0]         since_wait, since_req, since_read, since_rec;
  logic signed [12:0]  diff;
  logic [12:0]         mag;
  logic                bad;
  logic [1:0]          bus_ok;
  tss_pkg::res_word_t  res_word_next;

  assign accept     = tick_valid && !tick_stall;
  assign tick_stall = res_valid && res_stall;

  assign raw[0] = tick_word.raw_return;
  assign raw[1] = tick_word.raw_boiler;
  assign raw[2] = tick_word.raw_outdoor;

  always_comb begin
    lg_valid_next       = lg_valid;
    lg_value_next       = lg_value;
    held_quality_next   = held_quality;
    held_temp_next      = held_temp;
    phase_next          = phase;
    recovering_bus_next = recovering_bus;
    wait_until_next     = wait_until;
    error_streak_next   = error_streak;
    bus_recovering_next = bus_recovering;
    last_recovery_next  = last_recovery;
    last_request_next   = last_request;
    read_time_next      = read_time;
    req        = 1'b0;
    reinit     = 1'b0;
    pcycle     = 1'b0;
    rdone      = 1'b0;
    since_req  = '0;
    since_read = '0;
    since_rec  = '0;
    diff       = '0;
    mag        = '0;
    bad        = 1'b0;
    bus_ok     = '0;
    since_wait = tick_word.now_ms - wait_until;

    unique case (phase)
      tss_pkg::PH_IDLE: begin
      end
      tss_pkg::PH_POWER_OFF: begin
        if (!tick_word.cycling) begin
          phase_next      = tss_pkg::PH_WAIT_REINIT;
          wait_until_next = tick_word.now_ms + tss_pkg::ReinitWaitMs;
        end
      end
      default: begin
        if (phase != tss_pkg::PH_WAIT_REINIT || !since_wait[31]) begin
          reinit = (phase == tss_pkg::PH_WAIT_REINIT);
          req    = reinit;
          bus_recovering_next[recovering_bus] = 1'b0;
          error_streak_next[recovering_bus]   = '0;
          last_recovery_next[recovering_bus]  = tick_word.now_ms;
          phase_next = tss_pkg::PH_IDLE;
        end
      end
    endcase

    if (phase_next != tss_pkg::PH_IDLE) begin
      for (int i = 0; i < 3; i++) held_quality_next[i] = tss_pkg::Q_RECOVERING;
    end else if (!tick_word.powered) begin
      held_quality_next[0] = tss_pkg::Q_RECOVERING;
    end else begin
      since_req = tick_word.now_ms - last_request;
      if (last_request == '0 || since_req > tss_pkg::RequestPeriodMs) begin
        req               = 1'b1;
        last_request_next = tick_word.now_ms;
        read_time_next    = tick_word.now_ms + tss_pkg::ConversionMs;
      end
      since_read = tick_word.now_ms - read_time_next;
      if (!since_read[31]) begin
        rdone = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (!present_mask[i]) begin
            held_quality_next[i] = tss_pkg::Q_MISSING;
            held_temp_next[i]    = '0;
          end else begin
            diff = {raw[i][11], raw[i]} - {lg_value[i][11], lg_value[i]};
            mag  = diff[12] ? 13'(-diff) : 13'(diff);
            bad  = (raw[i] == tss_pkg::DisconnectedRaw) || (raw[i] <= tss_pkg::LowLimitRaw) ||
                   (raw[i] >= high_limit) || (lg_valid[i] && mag > {1'b0, max_jump});
            if (bad) begin
              held_quality_next[i] = tss_pkg::Q_IMPLAUSIBLE;
              held_temp_next[i]    = '0;
            end else begin
              held_quality_next[i] = tss_pkg::Q_OK;
              held_temp_next[i]    = raw[i];
              lg_valid_next[i]     = 1'b1;
              lg_value_next[i]     = raw[i];
            end
          end
        end
        bus_ok[0] = held_quality_next[0] == tss_pkg::Q_OK || !present_mask[0];
        bus_ok[1] = (held_quality_next[1] == tss_pkg::Q_OK || !present_mask[1]) &&
                    (held_quality_next[2] == tss_pkg::Q_OK || !present_mask[2]);
        for (int b = 0; b < 2; b++) begin
          if (bus_ok[b]) begin
            error_streak_next[b] = '0;
          end else begin
            if (error_streak_next[b] != tss_pkg::StreakMax) begin
              error_streak_next[b] = error_streak_next[b] + 8'd1;
            end
            since_rec = tick_word.now_ms - last_recovery_next[b];
            if (error_streak_next[b] >= streak_limit && !bus_recovering_next[b] &&
                (last_recovery_next[b] == '0 || since_rec > cooldown_ms) &&
                phase_next == tss_pkg::PH_IDLE) begin
              recovering_bus_next    = 1'(b);
              phase_next             = tss_pkg::PH_POWER_OFF;
              wait_until_next        = tick_word.now_ms;
              bus_recovering_next[b] = 1'b1;
              pcycle                 = 1'b1;
            end
          end
        end
      end
    end

    res_word_next.request_conversion = req;
    res_word_next.reinit_buses       = reinit;
    res_word_next.start_power_cycle  = pcycle;
    res_word_next.read_done          = rdone;
    res_word_next.quality_return     = held_quality_next[0];
    res_word_next.quality_boiler     = held_quality_next[1];
    res_word_next.quality_outdoor    = held_quality_next[2];
    res_word_next.temp_return  = (held_quality_next[0] == tss_pkg::Q_OK) ? held_temp_next[0] : '0;
    res_word_next.temp_boiler  = (held_quality_next[1] == tss_pkg::Q_OK) ? held_temp_next[1] : '0;
    res_word_next.temp_outdoor = (held_quality_next[2] == tss_pkg::Q_OK) ? held_temp_next[2] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_mask   <= tss_pkg::ResetPresentMask;
      high_limit     <= tss_pkg::ResetHighLimit;
      max_jump       <= tss_pkg::ResetMaxJump;
      streak_limit   <= tss_pkg::ResetStreakLimit;
      cooldown_ms    <= tss_pkg::ResetCooldownMs;
      lg_valid       <= '0;
      phase          <= tss_pkg::PH_IDLE;
      recovering_bus <= 1'b0;
      wait_until     <= '0;
      bus_recovering <= '0;
      last_request   <= '0;
      read_time      <= '0;
      for (int i = 0; i < 3; i++) begin
        held_quality[i] <= tss_pkg::Q_UNKNOWN;
        held_temp[i]    <= '0;
      end
      for (int b = 0; b < 2; b++) begin
        error_streak[b]  <= '0;
        last_recovery[b] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          tss_pkg::CfgPresentMask: present_mask <= cfg_data[2:0];
          tss_pkg::CfgHighLimit:   high_limit   <= cfg_data[11:0];
          tss_pkg::CfgMaxJump:     max_jump     <= cfg_data[11:0];
          tss_pkg::CfgStreakLimit: streak_limit <= cfg_data[7:0];
          tss_pkg::CfgCooldownMs:  cooldown_ms  <= cfg_data[31:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        lg_valid       <= lg_valid_next;
        held_quality   <= held_quality_next;
        held_temp      <= held_temp_next;
        phase          <= phase_next;
        recovering_bus <= recovering_bus_next;
        wait_until     <= wait_until_next;
        error_streak   <= error_streak_next;
        bus_recovering <= bus_recovering_next;
        last_recovery  <= last_recovery_next;
        last_request   <= last_request_next;
        read_time      <= read_time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lg_value <= lg_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_word <= res_word_next;
    end
  end

  `TSS_ALWAYS(a_one_bus_recovering, (phase != tss_pkg::PH_IDLE) == ($countones(bus_recovering) == 1), "recovery phase and bus flags disagree")
  `TSS_ALWAYS(a_recovering_bus_flag, (phase == tss_pkg::PH_IDLE) || bus_recovering[recovering_bus], "recovering bus has no flag set")
  `TSS_ASSERT(a_accept_gives_word, accept |=> res_valid, "accepted tick produced no result word")
  `TSS_ALWAYS(a_power_cycle_phase, !(res_valid && res_word.start_power_cycle) || (phase == tss_pkg::PH_POWER_OFF), "power cycle requested outside power off phase")
  `TSS_ALWAYS(a_reinit_idle, !(res_valid && res_word.reinit_buses) || (phase == tss_pkg::PH_IDLE) || res_word.start_power_cycle, "reinit issued while recovery still runs")

endmodule

// File: tb/tb_temp_sensor_supervisor.sv
// Self-checking testbench for temp_sensor_supervisor: tick words in, result words out.
// Predicts each result word from its own model of pacing, qualification and recovery.
// Depends on tss_pkg and the temp_sensor_supervisor RTL.
`timescale 1ns / 1ps

module tb_temp_sensor_supervisor;
  import tss_pkg::*;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 tick_valid = 1'b0;
  logic                 tick_stall;
  tick_word_t           tick_word = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  res_word_t            res_word;
  logic                 cfg_write = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  temp_sensor_supervisor DUT (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tick_word  (tick_word),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_word   (res_word),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Settings as the block holds them
  logic [2:0]         cfg_present;
  logic signed [11:0] cfg_high;
  logic [11:0]        cfg_jump;
  logic [7:0]         cfg_streak;
  logic [31:0]        cfg_cooldown;

  // Supervisor state
  logic               good_valid [3];
  logic signed [11:0] good_value [3];
  quality_t           held_q [3];
  logic signed [11:0] held_t [3];
  phase_t             seq_phase;
  logic               recov_bus;
  logic [31:0]        reinit_deadline;
  logic [7:0]         bad_streak [2];
  logic               bus_in_recovery [2];
  logic [31:0]        last_recovery_ms [2];
  logic [31:0]        last_request_ms;
  logic [31:0]        read_at_ms;

  res_word_t   awaited_results [$];
  int          mismatches = 0;
  logic [31:0] tick_clock_ms = '0;
  int          fault_left [3] = '{0, 0, 0};
  int          gapless_ticks = 0;
  int          stall_hold = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void qualify(input int i, input logic signed [11:0] t);
    int   tv;
    int   d;
    logic bad;
    tv = t;
    if (!cfg_present[i]) begin
      held_q[i] = Q_MISSING;
      held_t[i] = '0;
      return;
    end
    bad = (t == DisconnectedRaw) || (tv <= LowLimitRaw) || (tv >= cfg_high);
    if (!bad && good_valid[i]) begin
      d = tv - good_value[i];
      if (d < 0) d = -d;
      if (d > cfg_jump) bad = 1'b1;
    end
    if (bad) begin
      held_q[i] = Q_IMPLAUSIBLE;
      held_t[i] = '0;
      return;
    end
    held_q[i] = Q_OK;
    held_t[i] = t;
    good_valid[i] = 1'b1;
    good_value[i] = t;
  endfunction

  function automatic logic note_bus(input int b, input logic ok, input logic [31:0] now);
    logic [31:0] since;
    if (ok) begin
      bad_streak[b] = '0;
      return 1'b0;
    end
    if (bad_streak[b] != StreakMax) bad_streak[b]++;
    since = now - last_recovery_ms[b];
    if (bad_streak[b] >= cfg_streak && !bus_in_recovery[b] &&
        (last_recovery_ms[b] == 32'd0 || since > cfg_cooldown) && seq_phase == PH_IDLE) begin
      recov_bus = (b == 1);
      seq_phase = PH_POWER_OFF;
      reinit_deadline = now;
      bus_in_recovery[b] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_word_t supervise_tick(input tick_word_t w);
    res_word_t   r;
    logic [31:0] now;
    logic [31:0] since;
    logic        ok_bus1;
    logic        ok_bus2;
    r = '0;
    now = w.now_ms;
    if (seq_phase == PH_POWER_OFF) begin
      if (!w.cycling) begin
        seq_phase = PH_WAIT_REINIT;
        reinit_deadline = now + ReinitWaitMs;
      end
    end else if (seq_phase == PH_WAIT_REINIT) begin
      since = now - reinit_deadline;
      if (!since[31]) begin
        r.reinit_buses = 1'b1;
        r.request_conversion = 1'b1;
        bus_in_recovery[recov_bus] = 1'b0;
        bad_streak[recov_bus] = '0;
        last_recovery_ms[recov_bus] = now;
        seq_phase = PH_IDLE;
      end
    end
    if (seq_phase != PH_IDLE) begin
      for (int i = 0; i < 3; i++) held_q[i] = Q_RECOVERING;
    end else if (!w.powered) begin
      held_q[0] = Q_RECOVERING;
    end else begin
      since = now - last_request_ms;
      if (last_request_ms == 32'd0 || since > RequestPeriodMs) begin
        r.request_conversion = 1'b1;
        last_request_ms = now;
        read_at_ms = now + ConversionMs;
      end
      since = now - read_at_ms;
      if (!since[31]) begin
        r.read_done = 1'b1;
        qualify(0, w.raw_return);
        qualify(1, w.raw_boiler);
        qualify(2, w.raw_outdoor);
        ok_bus1 = held_q[0] == Q_OK || !cfg_present[0];
        ok_bus2 = (held_q[1] == Q_OK || !cfg_present[1]) &&
                  (held_q[2] == Q_OK || !cfg_present[2]);
        if (note_bus(0, ok_bus1, now)) r.start_power_cycle = 1'b1;
        if (note_bus(1, ok_bus2, now)) r.start_power_cycle = 1'b1;
      end
    end
    r.quality_return  = held_q[0];
    r.quality_boiler  = held_q[1];
    r.quality_outdoor = held_q[2];
    r.temp_return  = (held_q[0] == Q_OK) ? held_t[0] : 12'sd0;
    r.temp_boiler  = (held_q[1] == Q_OK) ? held_t[1] : 12'sd0;
    r.temp_outdoor = (held_q[2] == Q_OK) ? held_t[2] : 12'sd0;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_word_t want;
    logic      stall_pick;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result word with no tick word waiting");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("request_conversion", want.request_conversion,
                        res_word.request_conversion);
          compare_field("reinit_buses", want.reinit_buses, res_word.reinit_buses);
          compare_field("start_power_cycle", want.start_power_cycle,
                        res_word.start_power_cycle);
          compare_field("read_done", want.read_done, res_word.read_done);
          compare_field("quality_return", want.quality_return, res_word.quality_return);
          compare_field("quality_boiler", want.quality_boiler, res_word.quality_boiler);
          compare_field("quality_outdoor", want.quality_outdoor, res_word.quality_outdoor);
          compare_field("temp_return", want.temp_return, res_word.temp_return);
          compare_field("temp_boiler", want.temp_boiler, res_word.temp_boiler);
          compare_field("temp_outdoor", want.temp_outdoor, res_word.temp_outdoor);
        end
      end
      if (stall_hold > 0) begin
        stall_hold--;
      end else begin
        if (!res_stall && $urandom_range(99) < 35) begin
          stall_pick = 1'b1;
          stall_hold = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(2);
        end else begin
          stall_pick = 1'b0;
          stall_hold = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(5);
        end
        res_stall <= stall_pick;
      end
    end
  end

  task automatic send_tick(input tick_word_t w);
    int gap;
    int r;
    if (gapless_ticks > 0) begin
      gapless_ticks--;
      gap = 0;
    end else begin
      r = $urandom_range(99);
      if (r < 5) begin
        gapless_ticks = $urandom_range(80, 30);
        gap = 0;
      end else if (r < 50) begin
        gap = 0;
      end else if (r < 92) begin
        gap = $urandom_range(3, 1);
      end else begin
        gap = $urandom_range(25, 6);
      end
    end
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_word  <= w;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    awaited_results.push_back(supervise_tick(w));
  endtask

  task automatic drain_results();
    tick_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CfgPresentMask: cfg_present  = data[2:0];
      CfgHighLimit:   cfg_high     = data[11:0];
      CfgMaxJump:     cfg_jump     = data[11:0];
      CfgStreakLimit: cfg_streak   = data[7:0];
      CfgCooldownMs:  cfg_cooldown = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [2:0] mask, input logic signed [11:0] high,
                                input logic [11:0] jump, input logic [7:0] streak,
                                input logic [31:0] cooldown);
    logic [31:0] d;
    d = $urandom();
    d[2:0] = mask;
    write_reg(CfgPresentMask, d);
    d = $urandom();
    d[11:0] = high;
    write_reg(CfgHighLimit, d);
    d = $urandom();
    d[11:0] = jump;
    write_reg(CfgMaxJump, d);
    d = $urandom();
    d[7:0] = streak;
    write_reg(CfgStreakLimit, d);
    write_reg(CfgCooldownMs, cooldown);
    cfg_write <= 1'b0;
  endtask

  function automatic tick_word_t make_tick(input logic [31:0] now, input logic pw,
                                           input logic cy, input int r0, input int r1,
                                           input int r2);
    tick_word_t w;
    w.now_ms      = now;
    w.powered     = pw;
    w.cycling     = cy;
    w.raw_return  = r0[11:0];
    w.raw_boiler  = r1[11:0];
    w.raw_outdoor = r2[11:0];
    return w;
  endfunction

  // Mostly readings near the last good value; faults come in runs to build streaks.
  function automatic logic signed [11:0] pick_raw(input int i);
    int r;
    int base;
    int span;
    int v;
    if (fault_left[i] > 0) begin
      fault_left[i]--;
      return DisconnectedRaw;
    end
    r = $urandom_range(199);
    base = good_valid[i] ? int'(good_value[i]) : 320;
    span = (cfg_jump > 200) ? 200 : int'(cfg_jump);
    if (r < 4) begin
      fault_left[i] = $urandom_range(12, 3);
      v = DisconnectedRaw;
    end else if (r < 130) begin
      v = base + $urandom_range(2 * span) - span;
      if (v < -879) v = -879;
      if (v > 2047) v = 2047;
    end else if (r < 145) begin
      v = DisconnectedRaw;
    end else if (r < 165) begin
      v = $urandom_range(4095);
    end else if (r < 175) begin
      v = $urandom_range(1) ? -880 : -879;
    end else if (r < 185) begin
      v = cfg_high - $urandom_range(1);
    end else if ($urandom_range(1)) begin
      v = base + cfg_jump + 1 + $urandom_range(20);
    end else begin
      v = base - cfg_jump - 1 - $urandom_range(20);
    end
    return v[11:0];
  endfunction

  task automatic run_random_ticks(input int count);
    tick_word_t w;
    int         r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 2) tick_clock_ms = $urandom();
      else if (r < 4) tick_clock_ms = 32'hFFFF_FFFF - $urandom_range(1500);
      else if (r < 5) tick_clock_ms = 32'd0;
      else if (r >= 9) tick_clock_ms = tick_clock_ms + $urandom_range(260, 20);
      w.now_ms = tick_clock_ms;
      if (seq_phase == PH_POWER_OFF) begin
        w.cycling = $urandom_range(99) < 65;
        w.powered = w.cycling ? ($urandom_range(99) < 20) : ($urandom_range(99) < 90);
      end else begin
        w.cycling = $urandom_range(99) < 3;
        w.powered = $urandom_range(99) < 95;
      end
      w.raw_return  = pick_raw(0);
      w.raw_boiler  = pick_raw(1);
      w.raw_outdoor = pick_raw(2);
      send_tick(w);
    end
  endtask

  // Time zero, wrap, limits, jumps, power loss and one full recovery of bus 2.
  task automatic test_directed_ticks();
    send_tick(make_tick(32'd0, 1'b1, 1'b0, 320, 320, 320));
    send_tick(make_tick(32'd0, 1'b1, 1'b0, 320, 320, 320));
    send_tick(make_tick(32'hFFFF_FF00, 1'b1, 1'b0, 320, 320, 320));
    send_tick(make_tick(32'h1EE, 1'b1, 1'b0, 320, 2047, -2048));
    send_tick(make_tick(32'h1F0, 1'b1, 1'b0, -2032, -880, -879));
    send_tick(make_tick(32'h1F4, 1'b1, 1'b0, 481, 1359, -719));
    send_tick(make_tick(32'h200, 1'b0, 1'b0, 2047, -2048, 0));
    send_tick(make_tick(32'h208, 1'b1, 1'b1, 320, 1360, -719));
    send_tick(make_tick(32'h210, 1'b1, 1'b0, 320, -2032, -700));
    send_tick(make_tick(32'h218, 1'b1, 1'b0, 320, -2032, -700));
    send_tick(make_tick(32'h220, 1'b1, 1'b0, 320, -2032, -700));
    send_tick(make_tick(32'h228, 1'b1, 1'b0, 320, -2032, -700));
    send_tick(make_tick(32'h230, 1'b1, 1'b0, 320, -2032, -700));
    send_tick(make_tick(32'h238, 1'b0, 1'b1, 320, 320, -700));
    send_tick(make_tick(32'h240, 1'b1, 1'b0, 320, 320, -700));
    send_tick(make_tick(32'h300, 1'b1, 1'b0, 320, 320, -700));
    send_tick(make_tick(32'h434, 1'b1, 1'b0, 320, 320, -700));
    send_tick(make_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 320, 320, -700));
    send_tick(make_tick(32'h2ED, 1'b1, 1'b0, 2047, -2048, -1));
    send_tick(make_tick(32'h2F0, 1'b1, 1'b0, 330, 330, -690));
    tick_clock_ms = 32'h2F0;
    drain_results();
  endtask

  task automatic test_reset_settings();
    run_random_ticks(300);
    drain_results();
  endtask

  task automatic test_fast_recovery();
    apply_settings(3'd7, 12'sd2047, 12'd4095, 8'd1, 32'd0);
    run_random_ticks(300);
    drain_results();
  endtask

  task automatic test_extreme_limits();
    apply_settings(3'd0, -12'sd2048, 12'd0, 8'd255, 32'hFFFF_FFFF);
    run_random_ticks(100);
    drain_results();
    apply_settings(3'd6, 12'sd1360, 12'd0, 8'd255, 32'hFFFF_FFFF);
    run_random_ticks(100);
    drain_results();
  endtask

  task automatic test_streak_zero();
    apply_settings(3'd5, 12'sd1360, 12'd160, 8'd0, 32'd3000);
    run_random_ticks(250);
    drain_results();
  endtask

  task automatic test_random_settings();
    repeat (2) begin
      apply_settings(3'($urandom_range(7)), 12'($urandom_range(4095)),
                     12'($urandom_range(4095)), 8'($urandom_range(8)),
                     32'($urandom_range(20000)));
      run_random_ticks(175);
      drain_results();
    end
  endtask

  initial begin
    cfg_present  = ResetPresentMask;
    cfg_high     = ResetHighLimit;
    cfg_jump     = ResetMaxJump;
    cfg_streak   = ResetStreakLimit;
    cfg_cooldown = ResetCooldownMs;
    for (int i = 0; i < 3; i++) begin
      good_valid[i] = 1'b0;
      good_value[i] = '0;
      held_q[i]     = Q_UNKNOWN;
      held_t[i]     = '0;
    end
    for (int i = 0; i < 2; i++) begin
      bad_streak[i]       = '0;
      bus_in_recovery[i]  = 1'b0;
      last_recovery_ms[i] = '0;
    end
    seq_phase       = PH_IDLE;
    recov_bus       = 1'b0;
    reinit_deadline = '0;
    last_request_ms = '0;
    read_at_ms      = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_ticks();
    test_reset_settings();
    test_fast_recovery();
    test_extreme_limits();
    test_streak_zero();
    test_random_settings();

    repeat (5) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
